// ===== hw/rtl/wwvb_pkg.sv =====
package wwvb_pkg;

  typedef enum logic [1:0] {
    SYM_ZERO = 2'd0,
    SYM_ONE  = 2'd1,
    SYM_MARK = 2'd2,
    SYM_NONE = 2'd3
  } sym_t;

  typedef enum logic [1:0] {
    REG_LOW_AMP  = 2'd0,
    REG_HIGH_AMP = 2'd1,
    REG_DUT1_SGN = 2'd2,
    REG_DUT1_MAG = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    SRC_ZERO = 4'd0,
    SRC_MARK = 4'd1,
    SRC_MINT = 4'd2,
    SRC_MINU = 4'd3,
    SRC_HRT  = 4'd4,
    SRC_HRU  = 4'd5,
    SRC_DAYH = 4'd6,
    SRC_DAYT = 4'd7,
    SRC_DAYU = 4'd8,
    SRC_DSGN = 4'd9,
    SRC_DMAG = 4'd10,
    SRC_YRT  = 4'd11,
    SRC_YRU  = 4'd12,
    SRC_LEAP = 4'd13,
    SRC_DST  = 4'd14
  } src_t;

  typedef struct packed {
    src_t       src;
    logic [3:0] mask;
  } slot_t;

  typedef struct packed {
    logic [7:0] low_amplitude;
    logic [7:0] high_amplitude;
    logic [2:0] dut1_sign_bits;
    logic [3:0] dut1_magnitude;
  } cfg_t;

  localparam int SECONDS_PER_MINUTE = 60;
  localparam logic [12:0] PW_FIELD_MAX = 13'h1fff;
  localparam logic [7:0] RST_LOW_AMP = 8'd5;
  localparam logic [7:0] RST_HIGH_AMP = 8'd127;
  localparam logic [2:0] RST_DUT1_SGN = 3'd2;
  localparam logic [3:0] RST_DUT1_MAG = 4'd2;

  localparam slot_t FRAME [SECONDS_PER_MINUTE] = '{
    '{SRC_MARK, 4'd0}, '{SRC_MINT, 4'd4}, '{SRC_MINT, 4'd2}, '{SRC_MINT, 4'd1},
    '{SRC_ZERO, 4'd0}, '{SRC_MINU, 4'd8}, '{SRC_MINU, 4'd4}, '{SRC_MINU, 4'd2},
    '{SRC_MINU, 4'd1}, '{SRC_MARK, 4'd0}, '{SRC_ZERO, 4'd0}, '{SRC_ZERO, 4'd0},
    '{SRC_HRT,  4'd2}, '{SRC_HRT,  4'd1}, '{SRC_ZERO, 4'd0}, '{SRC_HRU,  4'd8},
    '{SRC_HRU,  4'd4}, '{SRC_HRU,  4'd2}, '{SRC_HRU,  4'd1}, '{SRC_MARK, 4'd0},
    '{SRC_ZERO, 4'd0}, '{SRC_ZERO, 4'd0}, '{SRC_DAYH, 4'd2}, '{SRC_DAYH, 4'd1},
    '{SRC_ZERO, 4'd0}, '{SRC_DAYT, 4'd8}, '{SRC_DAYT, 4'd4}, '{SRC_DAYT, 4'd2},
    '{SRC_DAYT, 4'd1}, '{SRC_MARK, 4'd0}, '{SRC_DAYU, 4'd8}, '{SRC_DAYU, 4'd4},
    '{SRC_DAYU, 4'd2}, '{SRC_DAYU, 4'd1}, '{SRC_ZERO, 4'd0}, '{SRC_ZERO, 4'd0},
    '{SRC_DSGN, 4'd4}, '{SRC_DSGN, 4'd2}, '{SRC_DSGN, 4'd1}, '{SRC_MARK, 4'd0},
    '{SRC_DMAG, 4'd8}, '{SRC_DMAG, 4'd4}, '{SRC_DMAG, 4'd2}, '{SRC_DMAG, 4'd1},
    '{SRC_ZERO, 4'd0}, '{SRC_YRT,  4'd8}, '{SRC_YRT,  4'd4}, '{SRC_YRT,  4'd2},
    '{SRC_YRT,  4'd1}, '{SRC_MARK, 4'd0}, '{SRC_YRU,  4'd8}, '{SRC_YRU,  4'd4},
    '{SRC_YRU,  4'd2}, '{SRC_YRU,  4'd1}, '{SRC_ZERO, 4'd0}, '{SRC_LEAP, 4'd1},
    '{SRC_ZERO, 4'd0}, '{SRC_DST,  4'd1}, '{SRC_DST,  4'd1}, '{SRC_MARK, 4'd0}
  };

  // x / 10, exact for x < 1029
  function automatic logic [6:0] div10(input logic [9:0] x);
    logic [17:0] p;
    p = 18'(x) * 18'd205;
    return p[17:11];
  endfunction

  // x / 100, exact for x < 1024
  function automatic logic [3:0] div100(input logic [9:0] x);
    logic [15:0] p;
    p = 16'(x) * 16'd41;
    return p[15:12];
  endfunction

endpackage

// ===== hw/rtl/wwvb_cfg_regs.sv =====
module wwvb_cfg_regs
  import wwvb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata,
  output cfg_t       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.low_amplitude  <= RST_LOW_AMP;
      cfg.high_amplitude <= RST_HIGH_AMP;
      cfg.dut1_sign_bits <= RST_DUT1_SGN;
      cfg.dut1_magnitude <= RST_DUT1_MAG;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_LOW_AMP:  cfg.low_amplitude  <= cfg_wdata;
        REG_HIGH_AMP: cfg.high_amplitude <= cfg_wdata;
        REG_DUT1_SGN: cfg.dut1_sign_bits <= cfg_wdata[2:0];
        REG_DUT1_MAG: cfg.dut1_magnitude <= cfg_wdata[3:0];
      endcase
    end
  end

endmodule

// ===== hw/rtl/wwvb_symbol.sv =====
module wwvb_symbol
  import wwvb_pkg::*;
(
  input  logic [5:0] second_of_minute,
  input  logic [5:0] minute,
  input  logic [4:0] hour,
  input  logic [8:0] day_of_year,
  input  logic [7:0] years_since_1900,
  input  logic       daylight_saving,
  input  cfg_t       cfg,
  output sym_t       symbol
);

  logic [9:0] day1;
  logic [6:0] mn_t, hr_t, day_q, yr_q;
  logic [3:0] day_h, yr_h;
  logic [9:0] mn_u, hr_u, day_t, day_u, yr_t, yr_u;
  logic       leap;
  slot_t      slot;
  logic [3:0] digit;

  always_comb begin
    day1  = 10'(day_of_year) + 10'd1;
    mn_t  = div10(10'(minute));
    hr_t  = div10(10'(hour));
    day_q = div10(day1);
    day_h = div100(day1);
    yr_q  = div10(10'(years_since_1900));
    yr_h  = div100(10'(years_since_1900));
    mn_u  = 10'(minute) - 10'(mn_t) * 10'd10;
    hr_u  = 10'(hour) - 10'(hr_t) * 10'd10;
    day_u = day1 - 10'(day_q) * 10'd10;
    day_t = 10'(day_q) - 10'(day_h) * 10'd10;
    yr_u  = 10'(years_since_1900) - 10'(yr_q) * 10'd10;
    yr_t  = 10'(yr_q) - 10'(yr_h) * 10'd10;
    // 1900 + y: divisible by 4 iff y is; century years only 1900, 2000, 2100
    leap  = (years_since_1900[1:0] == 2'b00) &&
            !((years_since_1900 == 8'd0) || (years_since_1900 == 8'd200));

    slot = (second_of_minute < 6'(SECONDS_PER_MINUTE)) ? FRAME[second_of_minute]
                                                       : slot_t'{SRC_ZERO, 4'd0};

    unique case (slot.src)
      SRC_MINT: digit = mn_t[3:0];
      SRC_MINU: digit = mn_u[3:0];
      SRC_HRT:  digit = hr_t[3:0];
      SRC_HRU:  digit = hr_u[3:0];
      SRC_DAYH: digit = day_h;
      SRC_DAYT: digit = day_t[3:0];
      SRC_DAYU: digit = day_u[3:0];
      SRC_DSGN: digit = {1'b0, cfg.dut1_sign_bits};
      SRC_DMAG: digit = cfg.dut1_magnitude;
      SRC_YRT:  digit = yr_t[3:0];
      SRC_YRU:  digit = yr_u[3:0];
      SRC_LEAP: digit = {3'b000, leap};
      SRC_DST:  digit = {3'b000, daylight_saving};
      default:  digit = 4'd0;
    endcase

    if (second_of_minute >= 6'(SECONDS_PER_MINUTE)) begin
      symbol = SYM_NONE;
    end else if (slot.src == SRC_MARK) begin
      symbol = SYM_MARK;
    end else if ((digit & slot.mask) != 4'd0) begin
      symbol = SYM_ONE;
    end else begin
      symbol = SYM_ZERO;
    end
  end

endmodule

// ===== hw/rtl/wwvb_time_code_sample_generator.sv =====
// WWVB amplitude time code, one carrier sample per transaction. Each input
// transaction carries the UTC time of the current second and the sample index
// within it; the output gives the carrier amplitude byte, the symbol sent this
// second and its reduced-carrier pulse width in samples (clamped to 8191 in the
// field). The block takes one transaction per clock unless stalled: an input
// register, one pass of digit and symbol logic, and an output register. A result
// passes through both registers in turn; the input stalls only while both
// registers hold a transaction and the output is not taken. Configuration
// writes take effect on the next clock and should be done while no transaction
// is in flight.
module wwvb_time_code_sample_generator
  import wwvb_pkg::*;
#(
  parameter int SAMPLES_PER_SECOND = 8000
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // second_of_minute[5:0], minute[11:6], hour[16:12], day_of_year[25:17],
  // years_since_1900[33:26], daylight_saving[34], sample_index[47:35]
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // amplitude[7:0], symbol[9:8], pulse_width[22:10], zero[23]
  output logic [23:0] m_axis_tdata
);

  localparam int PW_W = $clog2(SAMPLES_PER_SECOND + 1);
  localparam int CMP_W = (PW_W > 13) ? PW_W : 13;
  localparam logic [PW_W-1:0] PW_ZERO = PW_W'(SAMPLES_PER_SECOND / 5);
  localparam logic [PW_W-1:0] PW_ONE = PW_W'(SAMPLES_PER_SECOND / 2);
  localparam logic [PW_W-1:0] PW_MARK = PW_W'((SAMPLES_PER_SECOND * 4) / 5);
  localparam logic [PW_W-1:0] PW_FULL = PW_W'(SAMPLES_PER_SECOND);

  cfg_t        cfg;
  logic        in_vld;
  logic [47:0] in_data;
  logic        adv;
  sym_t        sym;
  logic [PW_W-1:0]  pw;
  logic [CMP_W-1:0] pw_ext;
  logic [12:0] pw_out;
  logic [7:0]  amp;

  wwvb_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  wwvb_symbol u_sym (
    .second_of_minute (in_data[5:0]),
    .minute           (in_data[11:6]),
    .hour             (in_data[16:12]),
    .day_of_year      (in_data[25:17]),
    .years_since_1900 (in_data[33:26]),
    .daylight_saving  (in_data[34]),
    .cfg              (cfg),
    .symbol           (sym)
  );

  assign adv = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !in_vld || adv;

  always_comb begin
    unique case (sym)
      SYM_ZERO: pw = PW_ZERO;
      SYM_ONE:  pw = PW_ONE;
      SYM_MARK: pw = PW_MARK;
      SYM_NONE: pw = PW_FULL;
    endcase
    pw_ext = CMP_W'(pw);
    pw_out = (pw_ext > CMP_W'(PW_FIELD_MAX)) ? PW_FIELD_MAX : pw_ext[12:0];
    amp = (CMP_W'(in_data[47:35]) < pw_ext) ? cfg.low_amplitude
                                            : cfg.high_amplitude;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld        <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tready) in_vld <= s_axis_tvalid;
      if (adv) m_axis_tvalid <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) in_data <= s_axis_tdata;
    if (adv && in_vld) m_axis_tdata <= {1'b0, pw_out, sym, amp};
  end

endmodule

// ===== hw/rtl/wwvb_checker.sv =====
module wwvb_checker
  import wwvb_pkg::*;
#(
  parameter int SAMPLES_PER_SECOND = 8000
) (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  localparam int ONE_W = SAMPLES_PER_SECOND / 2;
  localparam logic [12:0] ONE_FIELD = (ONE_W > 8191) ? 13'h1fff : 13'(ONE_W);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output transaction changed");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  a_one_width: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[9:8] == SYM_ONE) |-> m_axis_tdata[22:10] == ONE_FIELD)
    else $error("wrong pulse width for one bit");

endmodule

bind wwvb_time_code_sample_generator wwvb_checker #(
  .SAMPLES_PER_SECOND(SAMPLES_PER_SECOND)
) u_wwvb_checker (.*);
